// ===== sv/rlbb_pkg.sv =====
// Package for the ring/linear byte buffer engine: widths, command codes,
// front-to-back job record and the CRC-16/MODBUS byte step. No dependencies.
`default_nettype none
package rlbb_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned MaxXfer    = 8;
  localparam int unsigned AW         = $clog2(StoreDepth);
  localparam int unsigned PW         = AW + 1;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [3:0] {
    CMD_READ   = 4'd0,
    CMD_WRITE  = 4'd1,
    CMD_MOVE_R = 4'd2,
    CMD_MOVE_W = 4'd3,
    CMD_SET_R  = 4'd4,
    CMD_SET_W  = 4'd5,
    CMD_FILL   = 4'd6,
    CMD_CRC    = 4'd7,
    CMD_CLEAR  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    REG_RING    = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_DEFAULT = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    JOB_NONE  = 3'd0,
    JOB_READ  = 3'd1,
    JOB_WRITE = 3'd2,
    JOB_FILL  = 3'd3,
    JOB_CRC   = 3'd4
  } job_e;

  // One classified item as handed from the front to the back.
  typedef struct packed {
    job_e            job;
    logic            status;
    logic [AW-1:0]   start;
    logic [PW-1:0]   n;
    logic            rev;
    logic [7:0]      fill;
    logic [63:0]     wdata;
    logic [PW-1:0]   rptr;
    logic [PW-1:0]   wptr;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rlbb_front.sv =====
// Front end: holds pointers and configuration, checks each item and emits a job.
// Depends on rlbb_pkg.
`default_nettype none
module rlbb_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [1:0]             cfg_idx_i,
  input  wire [10:0]            cfg_data_i,
  input  wire                   push_i,
  output logic                  full_o,
  input  wire [3:0]             command_i,
  input  wire [10:0]            address_i,
  input  wire [10:0]            end_address_i,
  input  wire [10:0]            count_i,
  input  wire [1:0]             range_form_i,
  input  wire                   backward_i,
  input  wire                   wrap_once_i,
  input  wire                   reverse_order_i,
  input  wire [7:0]             fill_byte_i,
  input  wire [63:0]            write_data_i,
  output logic                  job_valid_o,
  input  wire                   job_ready_i,
  output rlbb_pkg::job_t        job_o,
  output logic [rlbb_pkg::PW-1:0] len_o
);
  import rlbb_pkg::*;

  logic          ring_q;
  logic [10:0]   blen_q;
  logic [PW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic          vld_q;
  job_t          job_q, job_d;
  logic [PW-1:0] len;
  logic          acc;

  always_comb begin
    if (blen_q == 11'd0) len = PW'(1);
    else if ({1'b0, blen_q} > 12'(StoreDepth)) len = PW'(StoreDepth);
    else len = PW'(blen_q);
  end
  assign len_o  = len;

  assign full_o      = vld_q && !job_ready_i;
  assign acc         = push_i && !full_o;
  assign job_valid_o = vld_q;
  assign job_o       = job_q;

  // Classification, all in 13-bit signed-free arithmetic.
  logic [12:0] a13, e13, c13, l13, p13, t13, s13, n13;
  logic        ok;
  always_comb begin
    a13 = 13'(address_i);
    e13 = 13'(end_address_i);
    c13 = 13'(count_i);
    l13 = 13'(len);
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    ok  = 1'b0;
    s13 = '0;
    n13 = '0;
    t13 = '0;
    p13 = '0;
    job_d = '0;
    job_d.job   = JOB_NONE;
    job_d.rev   = reverse_order_i;
    job_d.fill  = fill_byte_i;
    job_d.wdata = write_data_i;
    case (command_i)
      CMD_READ, CMD_WRITE: begin
        p13 = (command_i == CMD_READ) ? 13'(rptr_q) : 13'(wptr_q);
        if (c13 == 13'd0) ok = 1'b1;
        else if (c13 > 13'(MaxXfer) || c13 > l13) ok = 1'b0;
        else if (!ring_q && (p13 > l13 || c13 > l13 - p13)) ok = 1'b0;
        else begin
          ok = 1'b1;
          s13 = p13;
          n13 = c13;
          t13 = p13 + c13;
          if (ring_q && t13 >= l13) t13 = t13 - l13;
          if (command_i == CMD_READ) begin
            rptr_d = PW'(t13);
            job_d.job = JOB_READ;
          end else begin
            wptr_d = PW'(t13);
            job_d.job = JOB_WRITE;
          end
        end
      end
      CMD_MOVE_R, CMD_MOVE_W: begin
        p13 = (command_i == CMD_MOVE_R) ? 13'(rptr_q) : 13'(wptr_q);
        if (backward_i) begin
          t13 = p13 - c13;
          if (!ring_q) ok = !t13[12];
          else begin
            if (t13[12]) t13 = t13 + l13;
            ok = !t13[12];
          end
        end else begin
          t13 = p13 + c13;
          if (!ring_q) ok = (t13 <= l13);
          else begin
            if (t13 >= l13) t13 = t13 - l13;
            ok = (t13 < l13);
          end
        end
        if (ok) begin
          if (command_i == CMD_MOVE_R) rptr_d = PW'(t13);
          else wptr_d = PW'(t13);
        end
      end
      CMD_SET_R, CMD_SET_W: begin
        t13 = a13;
        if (!ring_q) ok = (t13 <= l13);
        else begin
          if (t13 >= l13 && wrap_once_i) t13 = t13 - l13;
          ok = (t13 < l13);
        end
        if (ok) begin
          if (command_i == CMD_SET_R) rptr_d = PW'(t13);
          else wptr_d = PW'(t13);
        end
      end
      CMD_FILL, CMD_CRC: begin
        // among fill jobs, rev marks clear jobs only
        job_d.rev = 1'b0;
        case (range_form_i)
          2'd0: begin
            if (a13 >= l13) ok = 1'b0;
            else if (c13 == 13'd0) ok = 1'b1;
            else if (c13 > l13) ok = 1'b0;
            else if (c13 > l13 - a13 && !ring_q) ok = 1'b0;
            else begin
              ok = 1'b1; s13 = a13; n13 = c13;
            end
          end
          2'd1: begin
            ok = 1'b1;
            if (ring_q) begin
              if (e13 >= l13) ok = 1'b0;
              if (e13 == 13'd0) e13 = l13;
            end else if (e13 > l13) ok = 1'b0;
            if (!ok) ok = 1'b0;
            else if (c13 == 13'd0) ok = 1'b1;
            else if (c13 > l13) ok = 1'b0;
            else if (c13 <= e13) begin
              s13 = e13 - c13; n13 = c13;
            end else if (!ring_q) ok = 1'b0;
            else begin
              s13 = l13 - (c13 - e13); n13 = c13;
            end
          end
          2'd2: begin
            ok = 1'b1;
            if (a13 >= l13) ok = 1'b0;
            else if (ring_q ? (e13 >= l13) : (e13 > l13)) ok = 1'b0;
            else if (e13 == a13) ok = 1'b1;
            else if (e13 > a13) begin
              s13 = a13; n13 = e13 - a13;
            end else if (!ring_q) ok = 1'b0;
            else begin
              s13 = a13; n13 = l13 - a13 + e13;
            end
          end
          default: ok = 1'b0;
        endcase
        if (ok && n13 != 13'd0) job_d.job = (command_i == CMD_FILL) ? JOB_FILL : JOB_CRC;
      end
      CMD_CLEAR: begin
        ok = 1'b1;
        s13 = '0;
        n13 = l13;
        job_d.job  = JOB_FILL;
        job_d.rev  = 1'b1;
        job_d.fill = 8'h00; // replaced by default value at the top level
      end
      default: ok = 1'b0;
    endcase
    job_d.status = !ok;
    job_d.start  = AW'(s13);
    job_d.n      = PW'(n13);
    job_d.rptr   = rptr_d;
    job_d.wptr   = wptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= 1'b0;
      blen_q <= 11'(StoreDepth);
      rptr_q <= '0;
      wptr_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_RING) begin
        ring_q <= cfg_data_i[0];
        rptr_q <= '0;
        wptr_q <= '0;
      end else if (cfg_we_i && cfg_idx_i == REG_LENGTH) begin
        blen_q <= cfg_data_i;
        rptr_q <= '0;
        wptr_q <= '0;
      end else if (acc) begin
        rptr_q <= rptr_d;
        wptr_q <= wptr_d;
      end
      if (acc) vld_q <= 1'b1;
      else if (job_ready_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) job_q <= job_d;
  end

endmodule
`default_nettype wire

// ===== sv/rlbb_back.sv =====
// Back end: byte store memory, byte-serial transfer, fill and CRC walker.
// Depends on rlbb_pkg.
`default_nettype none
module rlbb_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire [rlbb_pkg::PW-1:0]  len_i,
  input  wire [7:0]               dflt_i,
  input  wire                     job_valid_i,
  output logic                    job_ready_o,
  input  rlbb_pkg::job_t          job_i,
  output logic                    res_valid_o,
  input  wire                     res_pop_i,
  output logic                    status_o,
  output logic [63:0]             read_data_o,
  output logic [15:0]             crc_value_o,
  output logic [10:0]             read_pointer_o,
  output logic [10:0]             write_pointer_o
);
  import rlbb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } st_e;

  st_e           st_q;
  job_t          j_q;
  logic [AW-1:0] addr_q;
  logic [PW-1:0] idx_q;
  logic [AW-1:0] iaddr_q;
  logic [63:0]   rd_q;
  logic [15:0]   crc_q;
  logic [2:0]    rpos_q;
  logic          rvld_q;

  logic [7:0]    mem [StoreDepth];
  logic [7:0]    mrd_q;

  // result register
  logic          ov_q;
  logic          o_status_q;
  logic [63:0]   o_rd_q;
  logic [15:0]   o_crc_q;
  logic [10:0]   o_rp_q, o_wp_q;

  logic          take, finish, ld_out;
  logic [AW-1:0] addr_nx;
  logic [2:0]    bsel;

  assign job_ready_o = (st_q == ST_IDLE);
  assign take        = job_valid_i && job_ready_o;
  assign ld_out      = (st_q == ST_DONE) && (!ov_q || res_pop_i);
  assign res_valid_o = ov_q;
  assign status_o        = o_status_q;
  assign read_data_o     = o_rd_q;
  assign crc_value_o     = o_crc_q;
  assign read_pointer_o  = o_rp_q;
  assign write_pointer_o = o_wp_q;

  assign addr_nx = ({1'b0, addr_q} + PW'(1) >= len_i) ? '0 : AW'(addr_q + AW'(1));
  // byte index within transfer for current step
  assign bsel = j_q.rev ? 3'(j_q.n - PW'(1) - idx_q) : idx_q[2:0];
  assign finish = (idx_q + PW'(1) >= j_q.n);

  logic        we;
  logic [7:0]  wb;
  always_comb begin
    we = 1'b0;
    wb = j_q.fill;
    if (st_q == ST_INIT) begin
      we = 1'b1;
      wb = dflt_i;
    end else if (st_q == ST_RUN) begin
      if (j_q.job == JOB_FILL) we = 1'b1;
      if (j_q.job == JOB_WRITE) begin
        we = 1'b1;
        wb = j_q.wdata[{bsel, 3'b000} +: 8];
      end
    end
  end

  logic [AW-1:0] maddr;
  assign maddr = (st_q == ST_INIT) ? iaddr_q : addr_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[maddr] <= wb;
    mrd_q <= mem[maddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_INIT;
      iaddr_q <= '0;
      ov_q    <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      if (ld_out) ov_q <= 1'b1;
      else if (ov_q && res_pop_i) ov_q <= 1'b0;
      rvld_q <= 1'b0;
      case (st_q)
        ST_INIT: begin
          iaddr_q <= AW'(iaddr_q + AW'(1));
          if (iaddr_q == AW'(StoreDepth - 1)) st_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take) begin
            if (job_i.job == JOB_NONE) st_q <= ST_DONE;
            else st_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          rvld_q <= (j_q.job == JOB_READ) || (j_q.job == JOB_CRC);
          if (finish) st_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          st_q <= ST_DONE;
        end
        ST_DONE: begin
          if (ld_out) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      j_q    <= job_i;
      addr_q <= job_i.start;
      idx_q  <= '0;
      rd_q   <= '0;
      crc_q  <= 16'hFFFF;
    end else if (st_q == ST_RUN) begin
      addr_q <= addr_nx;
      idx_q  <= idx_q + PW'(1);
      rpos_q <= bsel;
    end
    if (rvld_q) begin
      if (j_q.job == JOB_READ) rd_q[{rpos_q, 3'b000} +: 8] <= mrd_q;
      else crc_q <= crc_byte(crc_q, mrd_q);
    end
    if (ld_out) begin
      o_status_q <= j_q.status;
      o_rd_q     <= (j_q.job == JOB_READ) ? rd_q : 64'd0;
      o_crc_q    <= (j_q.job == JOB_CRC) ? crc_q : 16'd0;
      o_rp_q     <= 11'(j_q.rptr);
      o_wp_q     <= 11'(j_q.wptr);
    end
  end

endmodule
`default_nettype wire

// ===== sv/ring_linear_byte_buffer_engine.sv =====
// Top level of the ring/linear byte buffer engine: front end, job queue
// stage and back end. Depends on rlbb_pkg, rlbb_front, rlbb_back.
//
//  channel   handshake          payload
//  input     push / full        command_i .. write_data_i
//  result    empty / pop        status_o .. write_pointer_o
//  config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// Each transfer, fill or CRC makes one memory port access per byte; a clear
// covers the whole length L. After reset the store is swept with the default
// byte while the back end takes no job. A held result stalls the back end;
// the front keeps one job ready.
`default_nettype none
module ring_linear_byte_buffer_engine (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire [1:0]   cfg_idx_i,
  input  wire [10:0]  cfg_data_i,
  input  wire         push,
  output logic        full,
  input  wire [3:0]   command_i,
  input  wire [10:0]  address_i,
  input  wire [10:0]  end_address_i,
  input  wire [10:0]  count_i,
  input  wire [1:0]   range_form_i,
  input  wire         backward_i,
  input  wire         wrap_once_i,
  input  wire         reverse_order_i,
  input  wire [7:0]   fill_byte_i,
  input  wire [63:0]  write_data_i,
  output logic        empty,
  input  wire         pop,
  output logic        status_o,
  output logic [63:0] read_data_o,
  output logic [15:0] crc_value_o,
  output logic [10:0] read_pointer_o,
  output logic [10:0] write_pointer_o
);
  import rlbb_pkg::*;

  logic [7:0]    dflt_q;
  logic          jv, jr, rv;
  job_t          jb, jb_fix;
  logic [PW-1:0] len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dflt_q <= 8'h00;
    else if (cfg_we_i && cfg_idx_i == REG_DEFAULT) dflt_q <= cfg_data_i[7:0];
  end

  // clear jobs are tagged by rev with a full-length fill; use default byte
  always_comb begin
    jb_fix = jb;
    if (jb.job == JOB_FILL && jb.rev) jb_fix.fill = dflt_q;
  end

  rlbb_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(push), .full_o(full),
    .command_i, .address_i, .end_address_i, .count_i, .range_form_i,
    .backward_i, .wrap_once_i, .reverse_order_i, .fill_byte_i, .write_data_i,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(jb),
    .len_o(len)
  );

  rlbb_back u_back (
    .clk_i, .rst_ni, .len_i(len), .dflt_i(dflt_q),
    .job_valid_i(jv), .job_ready_o(jr), .job_i(jb_fix),
    .res_valid_o(rv), .res_pop_i(pop),
    .status_o, .read_data_o, .crc_value_o, .read_pointer_o, .write_pointer_o
  );

  assign empty = !rv;

endmodule
`default_nettype wire
